### hdl/bcos_pkg.sv
// Package for the comment and string scanner.
// Holds the scan mode codes, character constants and state/flag types.
// No dependencies.
package bcos_pkg;

    typedef enum logic [2:0] {
        MODE_CODE       = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_STRING     = 3'd2,
        MODE_STRING_ESC = 3'd3,
        MODE_LINE       = 3'd4,
        MODE_BLOCK      = 3'd5,
        MODE_BLOCK_STAR = 3'd6
    } t_scan_mode;

    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_STAR      = 8'h2A;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

    typedef struct packed {
        t_scan_mode mode;
        logic       double_quote;
    } t_scan_state;

    typedef struct packed {
        logic block_open;
        logic inside_string;
        logic inside_line_comment;
    } t_scan_flags;

endpackage

### hdl/bcos_if.sv
// Request and result channel interfaces for the comment and string scanner.
// Depends on nothing; valid/ready handshake with payload fields.
interface bcos_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface bcos_out_if;
    logic valid;
    logic ready;
    logic block_open;
    logic inside_string;
    logic inside_line_comment;
    logic end_flag;

    modport source (output valid, output block_open, output inside_string,
                    output inside_line_comment, output end_flag, input ready);
    modport sink   (input valid, input block_open, input inside_string,
                    input inside_line_comment, input end_flag, output ready);
endinterface

### hdl/bcos_step.sv
// Next-context logic of the scanner for one byte.
// Depends on bcos_pkg for mode codes, characters and types.
module bcos_step (
    input  bcos_pkg::t_scan_state i_state,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output bcos_pkg::t_scan_state o_state,
    output bcos_pkg::t_scan_flags o_flags
);
    import bcos_pkg::*;

    t_scan_mode next_mode;
    logic       next_dq;
    logic [7:0] quote_char;

    always_comb begin
        quote_char = i_state.double_quote ? CHAR_DQUOTE : CHAR_SQUOTE;
        next_dq    = i_state.double_quote;
        next_mode  = MODE_CODE;
        case (i_state.mode)
            MODE_SLASH: begin
                if (i_byte == CHAR_SLASH) begin
                    next_mode = MODE_LINE;
                end else if (i_byte == CHAR_STAR) begin
                    next_mode = MODE_BLOCK;
                end else if (i_byte == CHAR_SQUOTE) begin
                    next_mode = MODE_STRING;
                    next_dq   = 1'b0;
                end else if (i_byte == CHAR_DQUOTE) begin
                    next_mode = MODE_STRING;
                    next_dq   = 1'b1;
                end else begin
                    next_mode = MODE_CODE;
                end
            end
            MODE_STRING: begin
                if (i_byte == CHAR_BACKSLASH) begin
                    next_mode = MODE_STRING_ESC;
                end else if (i_byte == quote_char) begin
                    next_mode = MODE_CODE;
                end else begin
                    next_mode = MODE_STRING;
                end
            end
            MODE_STRING_ESC: begin
                next_mode = MODE_STRING;
            end
            MODE_LINE: begin
                next_mode = (i_byte == CHAR_NEWLINE) ? MODE_CODE : MODE_LINE;
            end
            MODE_BLOCK: begin
                next_mode = (i_byte == CHAR_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
            end
            MODE_BLOCK_STAR: begin
                if (i_byte == CHAR_SLASH) begin
                    next_mode = MODE_CODE;
                end else if (i_byte == CHAR_STAR) begin
                    next_mode = MODE_BLOCK_STAR;
                end else begin
                    next_mode = MODE_BLOCK;
                end
            end
            default: begin
                if (i_byte == CHAR_SQUOTE) begin
                    next_mode = MODE_STRING;
                    next_dq   = 1'b0;
                end else if (i_byte == CHAR_DQUOTE) begin
                    next_mode = MODE_STRING;
                    next_dq   = 1'b1;
                end else if (i_byte == CHAR_SLASH) begin
                    next_mode = MODE_SLASH;
                end else begin
                    next_mode = MODE_CODE;
                end
            end
        endcase
    end

    always_comb begin
        o_flags.block_open          = (next_mode == MODE_BLOCK) ||
                                      (next_mode == MODE_BLOCK_STAR);
        o_flags.inside_string       = (next_mode == MODE_STRING) ||
                                      (next_mode == MODE_STRING_ESC);
        o_flags.inside_line_comment = (next_mode == MODE_LINE);
        if (i_last) begin
            o_state.mode         = MODE_CODE;
            o_state.double_quote = 1'b0;
        end else begin
            o_state.mode         = next_mode;
            o_state.double_quote = next_dq;
        end
    end

endmodule

### hdl/block_comment_open_scanner_unit.sv
// Top level of the C-style comment and string scanner.
// Depends on bcos_pkg, bcos_in_if/bcos_out_if and bcos_step.
//
//   channel  | dir | payload                                         | handshake
//   i_req    | in  | text_byte, last_byte                            | valid/ready
//   o_rsp    | out | block_open, inside_string, inside_line_comment, | valid/ready
//            |     | end_flag                                        |
//
// One byte per cycle sustained while o_rsp takes each result.
// An input register feeds the step logic, which updates the context register
// and loads the result register in the same cycle.
// i_rst_n (synchronous, active low) empties both registers and sets the context to code.
// A stalled result holds the pipeline; the input register still takes one request.
module block_comment_open_scanner_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    bcos_in_if.sink    i_req,
    bcos_out_if.source o_rsp
);
    import bcos_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_scan_state r_state;
    logic        r_out_valid;
    t_scan_flags r_out_flags;
    logic        r_out_last;

    t_scan_state n_state;
    t_scan_flags n_flags;
    logic        advance;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    bcos_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_flags (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_state.mode         <= MODE_CODE;
            r_state.double_quote <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.text_byte;
            r_in_last <= i_req.last_byte;
        end
        if (advance) begin
            r_out_flags <= n_flags;
            r_out_last  <= r_in_last;
        end
    end

    assign o_rsp.valid               = r_out_valid;
    assign o_rsp.block_open          = r_out_flags.block_open;
    assign o_rsp.inside_string       = r_out_flags.inside_string;
    assign o_rsp.inside_line_comment = r_out_flags.inside_line_comment;
    assign o_rsp.end_flag            = r_out_last;

endmodule
